>>> rtl/bmhq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the binary min-heap queue.
// No dependencies; every other file except bmhq_ram refers to this package by scoped name.
package bmhq_pkg;

  localparam int KEY_W  = 40;
  localparam int VTX_W  = 16;
  localparam int TAG_W  = 15;
  localparam int STAT_W = 2;
  localparam int FILL_W = 11;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VTX_W-1:0] vertex;
    logic [TAG_W-1:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [VTX_W-1:0]  vertex;
    logic [TAG_W-1:0]  tag;
    logic [STAT_W-1:0] status;
    logic [FILL_W-1:0] fill_count;
  } res_t;

endpackage

>>> rtl/bmhq_in_if.sv
`timescale 1ns / 1ps
// Request channel: push/pop operation with the entry to push.
// Depends on bmhq_pkg for field widths.
interface bmhq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [bmhq_pkg::KEY_W-1:0]  key;
  logic [bmhq_pkg::VTX_W-1:0]  vertex;
  logic [bmhq_pkg::TAG_W-1:0]  tag;

  modport source (output valid, op, key, vertex, tag, input ready);
  modport sink   (input valid, op, key, vertex, tag, output ready);
endinterface

>>> rtl/bmhq_out_if.sv
`timescale 1ns / 1ps
// Result channel: popped entry, status and fill count.
// Depends on bmhq_pkg for field widths.
interface bmhq_out_if;
  logic                         valid;
  logic                         ready;
  logic [bmhq_pkg::KEY_W-1:0]   out_key;
  logic [bmhq_pkg::VTX_W-1:0]   out_vertex;
  logic [bmhq_pkg::TAG_W-1:0]   out_tag;
  logic [bmhq_pkg::STAT_W-1:0]  status;
  logic [bmhq_pkg::FILL_W-1:0]  fill_count;

  modport source (output valid, out_key, out_vertex, out_tag, status, fill_count, input ready);
  modport sink   (input valid, out_key, out_vertex, out_tag, status, fill_count, output ready);
endinterface

>>> rtl/bmhq_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bmhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/bmhq_ctrl.sv
`timescale 1ns / 1ps
// Heap sequencer: sift-up and sift-down over the entry RAM, one level per
// step, with the moving entry held in a register (hole method, no swaps).
// Depends on bmhq_pkg.
module bmhq_ctrl #(
  parameter int CAPACITY = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_op,
  input  bmhq_pkg::entry_t                 in_entry,
  output logic                             res_valid,
  input  logic                             res_ready,
  output bmhq_pkg::res_t                   res,
  output logic                             ram_we,
  output logic [$clog2(CAPACITY)-1:0]      ram_waddr,
  output logic [bmhq_pkg::ENTRY_W-1:0]     ram_wdata,
  output logic [$clog2(CAPACITY)-1:0]      ram_raddr,
  input  logic [bmhq_pkg::ENTRY_W-1:0]     ram_rdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_UP_RD    = 4'd1;
  localparam logic [3:0] S_UP_CMP   = 4'd2;
  localparam logic [3:0] S_POP_ROOT = 4'd3;
  localparam logic [3:0] S_POP_LAST = 4'd4;
  localparam logic [3:0] S_DN_RL    = 4'd5;
  localparam logic [3:0] S_DN_RR    = 4'd6;
  localparam logic [3:0] S_DN_CMP   = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  bmhq_pkg::entry_t mov_r, mov_nxt;
  bmhq_pkg::entry_t lft_r, lft_nxt;
  bmhq_pkg::res_t   res_r, res_nxt;

  bmhq_pkg::entry_t rd_entry;
  logic [AW-1:0]    up_par, up_par2;
  logic [IW-1:0]    lc_w, rc_w, cnt_w, nlc_w;
  logic             lc_ok, rc_ok;
  logic             take_l, take_r;
  logic [bmhq_pkg::KEY_W-1:0] best_key;
  logic [AW-1:0]    npos;

  assign rd_entry = bmhq_pkg::entry_t'(ram_rdata);

  assign up_par  = (pos_r - 1'b1) >> 1;
  assign up_par2 = (up_par - 1'b1) >> 1;

  assign lc_w  = {1'b0, pos_r, 1'b1};
  assign rc_w  = lc_w + 1'b1;
  assign cnt_w = IW'(cnt_r);
  assign lc_ok = lc_w < cnt_w;
  assign rc_ok = rc_w < cnt_w;

  // Left child first; a child wins only on strictly smaller key.
  assign take_l   = lft_r.key < mov_r.key;
  assign best_key = take_l ? lft_r.key : mov_r.key;
  assign take_r   = rc_ok && (rd_entry.key < best_key);
  assign npos     = take_r ? AW'(rc_w) : AW'(lc_w);
  assign nlc_w    = {1'b0, npos, 1'b1};

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  // Each step writes the hole and reads a different slot further along the
  // path, and every operation ends before the next one reads, so no
  // forwarding is needed.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    mov_nxt   = mov_r;
    lft_nxt   = lft_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = mov_r;
    ram_raddr = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt.key    = '0;
          res_nxt.vertex = '0;
          res_nxt.tag    = '0;
          res_nxt.status = bmhq_pkg::ST_DONE;
          res_nxt.fill_count = bmhq_pkg::FILL_W'(cnt_r);
          if (in_op == bmhq_pkg::OP_PUSH) begin
            if (cnt_r == CW'(CAPACITY)) begin
              res_nxt.status = bmhq_pkg::ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              mov_nxt   = in_entry;
              pos_nxt   = AW'(cnt_r);
              cnt_nxt   = cnt_r + 1'b1;
              res_nxt.fill_count = bmhq_pkg::FILL_W'(cnt_r + 1'b1);
              state_nxt = S_UP_RD;
            end
          end else begin
            if (cnt_r == '0) begin
              res_nxt.status = bmhq_pkg::ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              ram_raddr = '0;
              cnt_nxt   = cnt_r - 1'b1;
              res_nxt.fill_count = bmhq_pkg::FILL_W'(cnt_r - 1'b1);
              state_nxt = S_POP_ROOT;
            end
          end
        end
      end

      S_UP_RD: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          ram_raddr = up_par;
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        ram_we = 1'b1;
        if (mov_r.key < rd_entry.key) begin
          // parent moves down into the hole
          ram_wdata = rd_entry;
          pos_nxt   = up_par;
          if (up_par == '0) begin
            state_nxt = S_UP_RD;
          end else begin
            ram_raddr = up_par2;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_POP_ROOT: begin
        res_nxt.key    = rd_entry.key;
        res_nxt.vertex = rd_entry.vertex;
        res_nxt.tag    = rd_entry.tag;
        ram_raddr      = AW'(cnt_r);
        state_nxt      = (cnt_r == '0) ? S_DONE : S_POP_LAST;
      end

      S_POP_LAST: begin
        mov_nxt   = rd_entry;
        pos_nxt   = '0;
        state_nxt = S_DN_RL;
      end

      S_DN_RL: begin
        if (lc_ok) begin
          ram_raddr = AW'(lc_w);
          state_nxt = S_DN_RR;
        end else begin
          ram_we    = 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_DN_RR: begin
        lft_nxt   = rd_entry;
        ram_raddr = AW'(rc_w);
        state_nxt = S_DN_CMP;
      end

      S_DN_CMP: begin
        ram_we = 1'b1;
        if (take_r || take_l) begin
          ram_wdata = take_r ? rd_entry : lft_r;
          pos_nxt   = npos;
          if (nlc_w < cnt_w) begin
            ram_raddr = AW'(nlc_w);
            state_nxt = S_DN_RR;
          end else begin
            state_nxt = S_DN_RL;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    mov_r <= mov_nxt;
    lft_r <= lft_nxt;
    res_r <= res_nxt;
  end

endmodule

>>> rtl/binary_min_heap_queue.sv
`timescale 1ns / 1ps
// Binary min-heap priority queue; one operation in flight at a time.
// Push: the entry climbs through S_UP_RD and S_UP_CMP, one level per compare, then the
// result is registered at the output; flagged requests go straight to S_DONE.
// Pop: the root and the last entry are read, then the hole sifts down via S_DN_RL/RR/CMP.
// The next request is taken the cycle after the result is posted; the single
// RAM read port sets the sift step. Synchronous active-low reset empties the heap.
module binary_min_heap_queue #(
  parameter int CAPACITY = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  bmhq_in_if.sink           in_ch,
  bmhq_out_if.source        out_ch
);

  localparam int AW = $clog2(CAPACITY);

  bmhq_pkg::entry_t                 in_entry;
  logic                             res_valid;
  logic                             res_ready;
  bmhq_pkg::res_t                   res;
  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr;
  logic [bmhq_pkg::ENTRY_W-1:0]     ram_wdata;
  logic [AW-1:0]                    ram_raddr;
  logic [bmhq_pkg::ENTRY_W-1:0]     ram_rdata;

  logic                             out_valid_r;
  bmhq_pkg::res_t                   out_r;

  assign in_entry.key    = in_ch.key;
  assign in_entry.vertex = in_ch.vertex;
  assign in_entry.tag    = in_ch.tag;

  bmhq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_op     (in_ch.op),
    .in_entry  (in_entry),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  bmhq_ram #(
    .WIDTH (bmhq_pkg::ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: a finished result waits here while the next request runs.
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_key    = out_r.key;
  assign out_ch.out_vertex = out_r.vertex;
  assign out_ch.out_tag    = out_r.tag;
  assign out_ch.status     = out_r.status;
  assign out_ch.fill_count = out_r.fill_count;

`ifndef NO_ASSERTIONS
  a_no_accept_while_posting: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !res_valid)
    else $error("request taken while a result is pending");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("pending result changed before transfer");

  a_error_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != bmhq_pkg::ST_DONE) |->
      (out_ch.out_key == '0 && out_ch.out_vertex == '0 && out_ch.out_tag == '0))
    else $error("flagged result carries payload");
`endif

endmodule
